/* sv/lphs_pkg.sv */
// Shared types and constants for the linear probing hash set.
// Used by the channel interfaces, the controller, the datapath and the top level.

package lphs_pkg;

   localparam int TABLE_SIZE = 1024;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int KEY_W      = 48;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [KEY_W-1:0] key_type;

   localparam idx_type LAST_SLOT = idx_type'(TABLE_SIZE - 1);

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_CHECK  = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_LIMIT = 2'd1,
      ST_ZERO  = 2'd2
   } status_type;

   // One table slot: the stored key and its tombstone mark.
   typedef struct packed {
      logic    tomb;
      key_type key;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic sweep_start;
      logic sweep_write;
      logic mem_read;
      logic probe_eval;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_clear;
      logic req_zero;
      logic sweep_last;
      logic probe_stop;
      logic probe_limit;
      logic out_free;
   } stat_type;

endpackage

/* sv/lphs_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on lphs_pkg for the key width.

interface lphs_req_if;
   logic                   valid;
   logic                   ready;
   logic [1:0]             kind;
   logic [lphs_pkg::KEY_W-1:0] key;

   modport source (output valid, output kind, output key, input ready);
   modport sink   (input valid, input kind, input key, output ready);
endinterface

interface lphs_rsp_if;
   logic       valid;
   logic       ready;
   logic       hit;
   logic [1:0] status;

   modport source (output valid, output hit, output status, input ready);
   modport sink   (input valid, input hit, input status, output ready);
endinterface

/* sv/lphs_ctrl.sv */
// Controller state machine of the hash set: sequences clearing sweeps, probes and responses.
// Depends on lphs_pkg for the command and status structs.

module lphs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lphs_pkg::stat_type stat,
   output lphs_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_READ  = 5'b00100,
      S_CHECK = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      clr_rsp_ff, clr_rsp_in;

   always_comb begin
      state_in   = state_ff;
      clr_rsp_in = clr_rsp_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.sweep_write = 1'b1;
            if (stat.sweep_last) begin
               clr_rsp_in = 1'b0;
               state_in   = clr_rsp_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               priority if (stat.req_clear) begin
                  cmd.sweep_start = 1'b1;
                  clr_rsp_in      = 1'b1;
                  state_in        = S_CLEAR;
               end else if (stat.req_zero) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            cmd.probe_eval = 1'b1;
            state_in = (stat.probe_stop || stat.probe_limit) ? S_RESP : S_READ;
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Reset starts in the sweep so the table memory is emptied before first use.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

endmodule

/* sv/lphs_dpath.sv */
// Datapath of the hash set: slot memory, probe registers, key compare and response register.
// Depends on lphs_pkg for widths, codes and the command and status structs.

module lphs_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_kind,
   input  lphs_pkg::key_type      req_key,
   input  lphs_pkg::cmd_type      cmd,
   output lphs_pkg::stat_type     stat,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic [1:0]             rsp_status
);

   lphs_pkg::entry_type mem [lphs_pkg::TABLE_SIZE];

   logic [1:0]          kind_ff;
   lphs_pkg::key_type   key_ff;
   lphs_pkg::idx_type   slot_ff, slot_in;
   lphs_pkg::idx_type   count_ff;
   lphs_pkg::idx_type   sweep_ff;
   lphs_pkg::entry_type rd_ff;
   logic                res_hit_ff;
   logic [1:0]          res_status_ff;
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [1:0]          rsp_status_ff;

   logic is_add, is_delete, slot_empty, key_match, live_match;
   logic probe_stop, probe_limit;

   assign is_add     = (kind_ff == lphs_pkg::KIND_ADD);
   assign is_delete  = (kind_ff == lphs_pkg::KIND_DELETE);
   assign slot_empty = (rd_ff.key == '0);
   assign key_match  = (rd_ff.key == key_ff);
   assign live_match = key_match && !rd_ff.tomb;

   // Add stops at an empty or equal slot, even a tombstoned one; the others skip tombstones.
   assign probe_stop  = is_add ? (slot_empty || key_match) : (slot_empty || live_match);
   assign probe_limit = !probe_stop && (count_ff == lphs_pkg::LAST_SLOT);

   assign slot_in = (slot_ff == lphs_pkg::LAST_SLOT) ? '0 : slot_ff + 1'b1;

   always_comb begin
      stat             = '0;
      stat.req_clear   = (req_kind == lphs_pkg::KIND_CLEAR);
      stat.req_zero    = (req_key == '0);
      stat.sweep_last  = (sweep_ff == lphs_pkg::LAST_SLOT);
      stat.probe_stop  = probe_stop;
      stat.probe_limit = probe_limit;
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Slot memory: one write port shared by the sweep and the probe, one registered read.
   always_ff @(posedge clock) begin
      if (cmd.sweep_write) begin
         mem[sweep_ff] <= '0;
      end else if (cmd.probe_eval && probe_stop && (is_add || (is_delete && live_match))) begin
         mem[slot_ff] <= '{tomb: is_delete, key: key_ff};
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         key_ff   <= req_key;
         slot_ff  <= lphs_pkg::idx_type'(req_key % lphs_pkg::TABLE_SIZE);
         count_ff <= '0;
         res_hit_ff <= 1'b0;
         if (req_kind != lphs_pkg::KIND_CLEAR && req_key == '0) begin
            res_status_ff <= lphs_pkg::ST_ZERO;
         end else begin
            res_status_ff <= lphs_pkg::ST_OK;
         end
      end else if (cmd.probe_eval) begin
         if (probe_stop) begin
            res_hit_ff <= !is_add && live_match;
         end else if (probe_limit) begin
            res_status_ff <= lphs_pkg::ST_LIMIT;
         end else begin
            slot_ff  <= slot_in;
            count_ff <= count_ff + 1'b1;
         end
      end
      if (cmd.rsp_load) begin
         rsp_hit_ff    <= res_hit_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.sweep_start) begin
            sweep_ff <= '0;
         end else if (cmd.sweep_write) begin
            sweep_ff <= (sweep_ff == lphs_pkg::LAST_SLOT) ? '0 : sweep_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_status = rsp_status_ff;

endmodule

/* sv/linear_probe_hash_set.sv */
// Top level of the linear probing hash set of 48-bit keys with tombstones.
// Depends on lphs_pkg, lphs_if, lphs_ctrl and lphs_dpath.
//
// Each request word (add, delete, check or clear) yields exactly one response word.
// Add, delete and check go from acceptance through a read of the slot memory and a compare for
// each of the P slots probed (1 to 1024), then load the response register. A zero key goes
// straight to the response register without probing.
// Clear, and reset, run a sweep that empties the 1024 slots one per cycle; a clear answers when
// the sweep is done, and no request is taken until the sweep after reset is done.
// A new request is taken while the previous response still waits in the output register.

module linear_probe_hash_set (
   input logic clock,
   input logic reset,
   lphs_req_if.sink   req_ch,
   lphs_rsp_if.source rsp_ch
);

   lphs_pkg::cmd_type  cmd;
   lphs_pkg::stat_type stat;
   logic               ctrl_ready;

   assign req_ch.ready = ctrl_ready;

   lphs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctrl_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lphs_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_kind   (req_ch.kind),
      .req_key    (req_ch.key),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_hit    (rsp_ch.hit),
      .rsp_status (rsp_ch.status)
   );

endmodule

/* test/tb_linear_probe_hash_set.sv */
// Self-checking testbench for linear_probe_hash_set: drives request words, predicts every
// response word with its own copy of the slot table and compares them in order.
// Depends on lphs_pkg, the lphs_req_if and lphs_rsp_if interfaces and the block's RTL.

module tb_linear_probe_hash_set;
   import lphs_pkg::*;

   localparam int      TIMEOUT_UNITS = 20_000_000;
   localparam int      MAX_WAIT      = 8;
   localparam int      POOL_SIZE     = 48;
   localparam int      STALL_AT      = 200;
   localparam int      STALL_CYCLES  = 600;
   localparam int      REPORT_LIMIT  = 10;
   localparam key_type KEY_MAX       = 48'hFFFF_FFFF_FFFF;
   // Same home slot as KEY_MAX, so it wraps around to slot 0.
   localparam key_type KEY_WRAP      = 48'hFFFF_FFFF_FBFF;

   typedef struct packed {
      kind_type kind;
      key_type  key;
   } request_word_type;

   typedef struct packed {
      logic       hit;
      status_type status;
   } answer_type;

   logic clock = 1'b0;
   logic reset;

   lphs_req_if req_ch ();
   lphs_rsp_if rsp_ch ();

   linear_probe_hash_set dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   key_type          table_key  [TABLE_SIZE];
   logic             table_tomb [TABLE_SIZE];
   request_word_type request_words [$];
   answer_type       expected_answers [$];
   key_type          key_pool [POOL_SIZE];

   int queued_count   = 0;
   int answered_count = 0;
   int failures       = 0;
   int send_wait      = 0;
   int send_max       = MAX_WAIT;
   int send_loads     = 0;
   int recv_wait      = 0;
   int recv_max       = MAX_WAIT;
   int recv_takes     = 0;
   int stall_left     = 0;
   bit stall_done     = 1'b0;
   bit req_taken      = 1'b0;
   bit rsp_taken      = 1'b0;

   function automatic void wipe_table();
      int i;
      for (i = 0; i < TABLE_SIZE; i++) begin
         table_key[i]  = '0;
         table_tomb[i] = 1'b0;
      end
   endfunction

   // Applies one request word to the table copy and returns the response it must produce.
   function automatic answer_type apply_to_table(kind_type kind, key_type key);
      answer_type ans;
      idx_type    slot;
      int         n;
      logic       done;
      ans.hit    = 1'b0;
      ans.status = ST_OK;
      done       = 1'b0;
      if (kind == KIND_CLEAR) begin
         wipe_table();
      end else if (key == '0) begin
         ans.status = ST_ZERO;
      end else begin
         slot = idx_type'(key % TABLE_SIZE);
         for (n = 0; n < TABLE_SIZE && !done; n++) begin
            if (kind == KIND_ADD) begin
               if (table_key[slot] == '0 || table_key[slot] == key) begin
                  table_key[slot]  = key;
                  table_tomb[slot] = 1'b0;
                  done = 1'b1;
               end
            end else if (table_key[slot] == '0) begin
               done = 1'b1;
            end else if (table_key[slot] == key && !table_tomb[slot]) begin
               if (kind == KIND_DELETE) table_tomb[slot] = 1'b1;
               ans.hit = 1'b1;
               done = 1'b1;
            end
            if (!done) slot = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
         end
         if (!done) ans.status = ST_LIMIT;
      end
      return ans;
   endfunction

   function automatic key_type random_key();
      return key_type'({$urandom(), $urandom()});
   endfunction

   function automatic int draw_wait(int max_wait);
      return (max_wait == 0) ? 0 : $urandom_range(0, max_wait);
   endfunction

   // A new idle limit now and then: most stretches may idle up to MAX_WAIT, some never idle.
   function automatic int pick_max();
      return ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
   endfunction

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
   endfunction

   task automatic queue_word(kind_type kind, key_type key);
      request_word_type w;
      w.kind = kind;
      w.key  = key;
      request_words.push_back(w);
      queued_count++;
   endtask

   task automatic wait_for_answers();
      do @(negedge clock); while (answered_count != queued_count);
   endtask

   // Request driver.
   always @(negedge clock) begin
      request_word_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_wait    <= 0;
      end else if (!req_ch.valid || req_taken) begin
         if (send_wait > 0) begin
            req_ch.valid <= 1'b0;
            send_wait    <= send_wait - 1;
         end else if (request_words.size() > 0) begin
            w = request_words.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.kind  <= w.kind;
            req_ch.key   <= w.key;
            send_wait    <= draw_wait(send_max);
            send_loads   <= send_loads + 1;
            if (send_loads % 64 == 63) send_max <= pick_max();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // One long hold-off of the response side, so the block backs up and stalls its input.
   always @(negedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (!stall_done && answered_count == STALL_AT) begin
         stall_left <= STALL_CYCLES;
         stall_done <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Response receiver.
   always @(negedge clock) begin
      int w;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_wait    <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_taken) begin
         w = draw_wait(recv_max);
         recv_takes <= recv_takes + 1;
         if (recv_takes % 64 == 63) recv_max <= pick_max();
         if (w > 0) begin
            rsp_ch.ready <= 1'b0;
            recv_wait    <= w - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end else if (recv_wait > 0) begin
         rsp_ch.ready <= 1'b0;
         recv_wait    <= recv_wait - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Monitor: predicts on every accepted request word, checks every accepted response word.
   always @(posedge clock) begin
      answer_type want;
      req_taken <= req_ch.valid && req_ch.ready;
      rsp_taken <= rsp_ch.valid && rsp_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready)
         expected_answers.push_back(apply_to_table(kind_type'(req_ch.kind), req_ch.key));
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         answered_count <= answered_count + 1;
         if (expected_answers.size() == 0) begin
            note_failure($sformatf("unexpected response word: hit %0b status %0d",
                                   rsp_ch.hit, rsp_ch.status));
         end else begin
            want = expected_answers.pop_front();
            if (rsp_ch.hit !== want.hit || rsp_ch.status !== want.status)
               note_failure($sformatf(
                  "response %0d mismatch: expected hit %0b status %0d, got hit %0b status %0d",
                  answered_count, want.hit, want.status, rsp_ch.hit, rsp_ch.status));
         end
      end
   end

   initial begin
      key_type  k;
      key_type  kept_a;
      key_type  kept_b;
      kind_type kind;
      int       i;
      int       r;

      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind  = KIND_ADD;
      req_ch.key   = '0;
      rsp_ch.ready = 1'b0;
      wipe_table();
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed words: empty table, zero keys, wraparound, tombstones, revival, clear.
      queue_word(KIND_CHECK, 48'd5);
      queue_word(KIND_ADD, '0);
      queue_word(KIND_DELETE, '0);
      queue_word(KIND_CHECK, '0);
      queue_word(KIND_ADD, KEY_MAX);
      queue_word(KIND_ADD, KEY_WRAP);
      queue_word(KIND_CHECK, KEY_WRAP);
      queue_word(KIND_ADD, 48'd1024);
      queue_word(KIND_ADD, 48'd1);
      queue_word(KIND_ADD, 48'd1);
      queue_word(KIND_DELETE, KEY_MAX);
      queue_word(KIND_DELETE, KEY_MAX);
      queue_word(KIND_CHECK, KEY_MAX);
      queue_word(KIND_CHECK, KEY_WRAP);
      queue_word(KIND_ADD, KEY_MAX);
      queue_word(KIND_CHECK, KEY_MAX);
      queue_word(KIND_DELETE, 48'd1024);
      queue_word(KIND_DELETE, 48'd1);
      queue_word(KIND_CHECK, 48'd1);
      queue_word(KIND_ADD, 48'd1);
      queue_word(KIND_CHECK, 48'd1);
      queue_word(KIND_ADD, 48'hAAAA_AAAA_AAAA);
      queue_word(KIND_ADD, 48'h5555_5555_5555);
      queue_word(KIND_CLEAR, KEY_MAX);
      queue_word(KIND_CHECK, KEY_MAX);
      queue_word(KIND_CLEAR, '0);
      wait_for_answers();

      // Keys clustered on a few home slots near both ends of the table, so chains
      // form, overlap and wrap.
      for (i = 0; i < POOL_SIZE; i++) begin
         k = random_key();
         k[IDX_W-1:0] = (i < 36) ? idx_type'($urandom_range(0, 11))
                                 : idx_type'($urandom_range(TABLE_SIZE - 6, TABLE_SIZE - 1));
         if (k == '0) k[IDX_W] = 1'b1;
         key_pool[i] = k;
      end
      for (i = 0; i < 900; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40)      kind = KIND_ADD;
         else if (r < 65) kind = KIND_DELETE;
         else if (r < 99) kind = KIND_CHECK;
         else             kind = KIND_CLEAR;
         r = $urandom_range(0, 99);
         if (r < 5)       k = '0;
         else if (r < 15) k = random_key();
         else             k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         queue_word(kind, k);
      end
      wait_for_answers();

      // Fill every slot, then run the probe limit cases on the full table.
      queue_word(KIND_CLEAR, random_key());
      for (i = 0; i < TABLE_SIZE; i++) begin
         k = random_key();
         k[IDX_W-1:0] = idx_type'(i);
         if (k == '0) k[IDX_W] = 1'b1;
         if (i == 5) kept_a = k;
         if (i == 700) kept_b = k;
         queue_word(KIND_ADD, k);
      end
      k = kept_a ^ 48'h8000_0000_0000;
      queue_word(KIND_ADD, k);
      queue_word(KIND_ADD, kept_a);
      queue_word(KIND_CHECK, k);
      queue_word(KIND_DELETE, k);
      queue_word(KIND_DELETE, kept_b);
      queue_word(KIND_CHECK, kept_b);
      queue_word(KIND_ADD, kept_b);
      queue_word(KIND_CHECK, kept_b);
      queue_word(KIND_DELETE, kept_a);
      queue_word(KIND_ADD, k);
      queue_word(KIND_CHECK, '0);
      queue_word(KIND_CLEAR, '0);
      queue_word(KIND_CHECK, kept_b);
      wait_for_answers();

      repeat (20) @(negedge clock);
      if (expected_answers.size() != 0)
         note_failure($sformatf("%0d response words never arrived", expected_answers.size()));
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_UNITS;
      $display("Verification failed");
      $finish;
   end

endmodule
